// ----- rtl/nss_pkg.sv -----
// Package for the non-overlapping substring search unit.
// Holds widths, register indexes and shared types; no dependencies.
package nss_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_W       = 30;
  localparam int NAS_W       = POS_W + 1;
  localparam int CNT_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_WORDS   = 4;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;

  localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(1);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);
  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0    = 3'd0,
    REG_PAT1    = 3'd1,
    REG_PAT2    = 3'd2,
    REG_PAT3    = 3'd3,
    REG_PAT_LEN = 3'd4,
    REG_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_PATTERN-1:0] window_t;
  typedef logic [PAT_WORDS*64-1:0] pattern_t;

endpackage

// ----- rtl/nss_match.sv -----
// Window comparator: checks the newest len bytes against the pattern.
// Depends on nss_pkg.
module nss_match import nss_pkg::*; (
  input  window_t          window,
  input  pattern_t         pattern,
  input  logic [LEN_W-1:0] len_eff,
  output logic             hit
);

  logic [MAX_PATTERN-1:0] eq;

  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sel = len_eff - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) >= len_eff) begin
        eq[k] = 1'b1;
      end else begin
        eq[k] = (window[sel[IDX_W-1:0]] == pattern[8*k +: 8]);
      end
    end
    hit = &eq;
  end

endmodule

// ----- rtl/nonoverlap_substring_search_unit.sv -----
// Top level of the non-overlapping substring search unit.
// Depends on nss_pkg and nss_match.
//
// Usage: the bytes of one object enter on the in_ stream, one byte per word,
// with in_tlast on the final byte. Every leftmost non-overlapping occurrence
// of the pattern (1 to 32 bytes, set through the cfg_ write port) gives a
// result word with out_tuser high and the start offset, while fewer than
// match_limit matches have been reported. The final byte also gives a done
// word with out_tlast high carrying the capped count; a byte that both ends
// a match and ends the object gives the match word first, then the done word.
// A result is registered in the result slots when its byte is taken.
// Throughput: one byte per cycle while out_tready is high, set by the two-slot
// result register; a byte with two results stalls in_ till the match word leaves.
// When the receiver stalls, results hold and in_tready drops once the slots
// cannot be freed. Reset clears the window, counters and result slots, sets
// the pattern to zeros, the length to 1 and the limit to 64. Write the
// configuration only while no results are outstanding.
module nonoverlap_substring_search_unit import nss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [29:0] match_position,
                                            // [40:30] recorded_count, rest 0
  output logic                  out_tuser,  // match_found
  output logic                  out_tlast,  // search_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PAT_WORDS-1:0][63:0] pat_r;
  logic [LEN_W-1:0]           len_r;
  logic [CNT_W-1:0]           limit_r;

  window_t          wnd_r, wnd_nxt, wnd_shift;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [NAS_W-1:0] nas_r, nas_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             m_valid_r, m_valid_nxt;
  logic             d_valid_r, d_valid_nxt;
  logic [POS_W-1:0] m_pos_r, m_pos_nxt;
  logic [CNT_W-1:0] m_cnt_r, m_cnt_nxt;
  logic [CNT_W-1:0] d_cnt_r, d_cnt_nxt;

  logic [LEN_W-1:0] len_eff;
  logic [NAS_W-1:0] pos_inc, start;
  logic             hit, in_fire, out_fire, emit;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      len_r   <= LEN_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT0:    pat_r[0] <= cfg_wdata;
        REG_PAT1:    pat_r[1] <= cfg_wdata;
        REG_PAT2:    pat_r[2] <= cfg_wdata;
        REG_PAT3:    pat_r[3] <= cfg_wdata;
        REG_PAT_LEN: len_r    <= cfg_wdata[LEN_W-1:0];
        REG_LIMIT:   limit_r  <= cfg_wdata[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  // window with the incoming byte shifted in
  always_comb begin
    wnd_shift[0] = in_tdata[7:0];
    for (int j = 1; j < MAX_PATTERN; j++) begin
      wnd_shift[j] = wnd_r[j-1];
    end
  end

  nss_match u_match (
    .window  (wnd_shift),
    .pattern (pat_r),
    .len_eff (len_eff),
    .hit     (hit)
  );

  assign out_fire = out_tvalid && out_tready;
  assign in_tready = (!m_valid_r && !d_valid_r) ||
                     (out_tready && (m_valid_r ^ d_valid_r));
  assign in_fire  = in_tvalid && in_tready;

  assign pos_inc = {1'b0, pos_r} + NAS_W'(1);
  assign start   = pos_inc - NAS_W'(len_eff);

  always_comb begin
    wnd_nxt     = wnd_r;
    pos_nxt     = pos_r;
    nas_nxt     = nas_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    m_pos_nxt   = m_pos_r;
    m_cnt_nxt   = m_cnt_r;
    d_cnt_nxt   = d_cnt_r;
    m_valid_nxt = m_valid_r;
    d_valid_nxt = d_valid_r;
    if (in_fire) begin
      wnd_nxt = wnd_shift;
      if ((pos_inc >= NAS_W'(len_eff)) && (start >= nas_r) && hit) begin
        nas_nxt = pos_inc;
        if (cnt_r < limit_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          emit    = 1'b1;
        end
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
      m_pos_nxt   = start[POS_W-1:0];
      m_cnt_nxt   = cnt_nxt;
      d_cnt_nxt   = cnt_nxt;
      m_valid_nxt = emit;
      d_valid_nxt = in_tlast;
      if (in_tlast) begin
        wnd_nxt = '0;
        pos_nxt = '0;
        nas_nxt = '0;
        cnt_nxt = '0;
      end
    end else if (out_fire) begin
      if (m_valid_r) begin
        m_valid_nxt = 1'b0;
      end else begin
        d_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wnd_r     <= '0;
      pos_r     <= '0;
      nas_r     <= '0;
      cnt_r     <= '0;
      m_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      wnd_r     <= wnd_nxt;
      pos_r     <= pos_nxt;
      nas_r     <= nas_nxt;
      cnt_r     <= cnt_nxt;
      m_valid_r <= m_valid_nxt;
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_pos_r <= m_pos_nxt;
    m_cnt_r <= m_cnt_nxt;
    d_cnt_r <= d_cnt_nxt;
  end

  // present the match word before the done word
  assign out_tvalid = m_valid_r || d_valid_r;
  assign out_tuser  = m_valid_r;
  assign out_tlast  = !m_valid_r && d_valid_r;
  assign out_tdata  = m_valid_r ?
                      {{(OUT_DATA_W-POS_W-CNT_W){1'b0}}, m_cnt_r, m_pos_r} :
                      {{(OUT_DATA_W-POS_W-CNT_W){1'b0}}, d_cnt_r, {POS_W{1'b0}}};

  a_two_pending_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && d_valid_r) |-> !in_tready)
    else $error("input taken while two results pending");

  a_nas_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nas_r <= pos_inc)
    else $error("next allowed start beyond position plus one");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (pos_r == '0 && cnt_r == '0 && nas_r == '0))
    else $error("object state not cleared after last byte");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> d_valid_r)
    else $error("no done result after last byte");

endmodule

// ----- tb/sv/nonoverlap_substring_search_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nonoverlap_substring_search_unit: drives object bytes,
// predicts match and done words in-house and compares them with the out_ stream.
// Depends on nss_pkg and the unit's RTL.
module nonoverlap_substring_search_unit_test;
  import nss_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_BYTES    = 65;
  localparam int N_PHASES       = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  last;
  } byte_word_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             done;
    logic [CNT_W-1:0] count;
  } match_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nonoverlap_substring_search_unit dut (.*);

  // configuration as the block should hold it
  pattern_t         pattern_bytes = '0;
  logic [LEN_W-1:0] pattern_len_reg = LEN_RESET;
  logic [CNT_W-1:0] report_limit = LIMIT_RESET;

  // per-object search state
  window_t          scan_window = '0;
  int unsigned      scan_pos = 0;
  int unsigned      scan_next_start = 0;
  logic [CNT_W-1:0] scan_reported = '0;

  byte_word_t    byte_queue[$];
  match_result_t expected_results[$];

  bit in_taken = 1'b0;
  bit idle_bursts = 1'b1;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int bytes_taken = 0;
  int stuck_cycles = 0;
  int mismatches = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_pattern_len();
    if (pattern_len_reg == 0) return 1;
    if (pattern_len_reg > MAX_PATTERN) return MAX_PATTERN;
    return 32'(pattern_len_reg);
  endfunction

  function automatic void predict_byte(byte_t data, logic last);
    int unsigned len;
    int unsigned start;
    bit hit;
    match_result_t r;
    len = eff_pattern_len();
    scan_window = {scan_window[MAX_PATTERN-2:0], data};
    if (scan_pos + 1 >= len) begin
      start = scan_pos + 1 - len;
      if (start >= scan_next_start) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (scan_window[len-1-i] != pattern_bytes[i*8 +: 8]) hit = 1'b0;
        end
        if (hit) begin
          scan_next_start = scan_pos + 1;
          if (scan_reported < report_limit) begin
            scan_reported = scan_reported + 1'b1;
            r.position = POS_W'(start);
            r.found    = 1'b1;
            r.done     = 1'b0;
            r.count    = scan_reported;
            expected_results = {expected_results, r};
          end
        end
      end
    end
    if (scan_pos < POS_MAX) scan_pos++;
    if (last) begin
      r.position = '0;
      r.found    = 1'b0;
      r.done     = 1'b1;
      r.count    = scan_reported;
      expected_results = {expected_results, r};
      scan_window     = '0;
      scan_pos        = 0;
      scan_next_start = 0;
      scan_reported   = '0;
    end
  endfunction

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endfunction

  function automatic void check_result();
    match_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected word, expected none, got tdata=%h tuser=%b tlast=%b",
               $time, out_tdata, out_tuser, out_tlast);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (out_tdata[POS_W-1:0] !== want.position)
        report("match_position", 32'(want.position), 32'(out_tdata[POS_W-1:0]));
      if (out_tdata[POS_W +: CNT_W] !== want.count)
        report("recorded_count", 32'(want.count), 32'(out_tdata[POS_W +: CNT_W]));
      if (out_tdata[OUT_DATA_W-1:POS_W+CNT_W] !== '0)
        report("tdata padding", 32'd0, 32'(out_tdata[OUT_DATA_W-1:POS_W+CNT_W]));
      if (out_tuser !== want.found)
        report("match_found", 32'(want.found), 32'(out_tuser));
      if (out_tlast !== want.done)
        report("search_done", 32'(want.done), 32'(out_tlast));
    end
  endfunction

  // sample both streams
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_byte(in_tdata, in_tlast);
      bytes_taken <= bytes_taken + 1;
    end
    if (rst_n && out_tvalid && out_tready) check_result();
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  // feed bytes from the queue, with random gaps
  always @(negedge clk) begin : drive_bytes
    byte_word_t next_word;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
        send_gap  <= $urandom_range(0, 11);
        in_tvalid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        next_word = byte_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_word.data;
        in_tlast  <= next_word.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold while bytes keep coming
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && bytes_taken >= 300 && byte_queue.size() > 50) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PAT0:    pattern_bytes[0 +: 64]   = value;
      REG_PAT1:    pattern_bytes[64 +: 64]  = value;
      REG_PAT2:    pattern_bytes[128 +: 64] = value;
      REG_PAT3:    pattern_bytes[192 +: 64] = value;
      REG_PAT_LEN: pattern_len_reg = value[LEN_W-1:0];
      REG_LIMIT:   report_limit = value[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_pattern(input pattern_t p);
    write_reg(REG_PAT0, p[0 +: 64]);
    write_reg(REG_PAT1, p[64 +: 64]);
    write_reg(REG_PAT2, p[128 +: 64]);
    write_reg(REG_PAT3, p[192 +: 64]);
  endtask

  // hold until every byte is taken and every word has arrived
  task automatic drain();
    while (byte_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_object(input logic [63:0] seq, input int n);
    byte_word_t w;
    for (int k = 0; k < n; k++) begin
      w.data = seq[k*8 +: 8];
      w.last = (k == n - 1);
      byte_queue = {byte_queue, w};
    end
  endfunction

  function automatic pattern_t random_pattern(input int unsigned mode);
    pattern_t p;
    byte_t    sym[3];
    for (int i = 0; i < 3; i++) sym[i] = byte_t'($urandom);
    for (int k = 0; k < MAX_PATTERN; k++)
      p[k*8 +: 8] = (mode >= 2) ? byte_t'($urandom) : sym[$urandom_range(0, mode + 1)];
    return p;
  endfunction

  // objects built from whole and partial pattern copies and noise; the last one may stay open
  function automatic void queue_random_bytes(input int count);
    int unsigned eff;
    int unsigned obj_left;
    int unsigned copy_idx;
    int unsigned copy_end;
    byte_word_t  w;
    eff      = eff_pattern_len();
    obj_left = 0;
    copy_idx = 0;
    copy_end = 0;
    repeat (count) begin
      if (obj_left == 0)
        obj_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(eff, eff * 3 + 8);
      if (copy_idx == copy_end) begin
        copy_idx = 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: copy_end = eff;
          5, 6:          copy_end = $urandom_range(1, eff);
          default:       copy_end = 0;
        endcase
      end
      if (copy_idx != copy_end) begin
        w.data = pattern_bytes[copy_idx*8 +: 8];
        copy_idx++;
      end else if ($urandom_range(0, 3) == 0) begin
        w.data = byte_t'($urandom);
      end else begin
        w.data = pattern_bytes[$urandom_range(0, eff - 1)*8 +: 8];
      end
      w.last = (obj_left == 1);
      obj_left--;
      byte_queue = {byte_queue, w};
    end
  endfunction

  initial begin
    int len_plan[N_PHASES];
    int limit_plan[N_PHASES];
    len_plan   = '{1, 32, 2, 63, 4, 0, 3, 33, 8, 69};
    limit_plan = '{2, 1024, 0, 3, 2047, 1, 64, 2051, 5, 64};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero byte, length 1
    queue_object(64'hFF0000, 3);
    drain();

    // length 0 acts as 1; match and done on one byte
    write_reg(REG_PAT0, 64'hFF);
    write_reg(REG_PAT_LEN, 64'd0);
    queue_object(64'hFF, 1);
    drain();

    // overlapping occurrences are skipped; unused indexes must not disturb anything
    write_reg(REG_PAT0, 64'h616261);
    write_reg(REG_PAT_LEN, 64'd3);
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, '1);
    queue_object(64'h61626162616261, 7);
    // no match across an object boundary
    queue_object(64'h6261, 2);
    queue_object(64'h616261, 3);
    drain();

    write_reg(REG_LIMIT, 64'd1);
    queue_object(64'h616261616261, 6);
    drain();
    write_reg(REG_LIMIT, 64'd0);
    queue_object(64'h616261, 3);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_pattern(random_pattern(ph % 3));
      write_reg(REG_PAT_LEN, 64'(len_plan[ph]));
      write_reg(REG_LIMIT, 64'(limit_plan[ph]));
      if (ph == N_PHASES - 1) idle_bursts = 1'b0;
      queue_random_bytes(PHASE_BYTES);
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/nss_pkg.sv
rtl/nss_match.sv
rtl/nonoverlap_substring_search_unit.sv
tb/sv/nonoverlap_substring_search_unit_test.sv
